/* hdl/sptw_pkg.sv */
// package for the sv39 page table walker: payload structs, codes, fsm states
// and controller/datapath command and status structs; no dependencies
package sptw_pkg;

  localparam int unsigned STORE_PAGES_DEF  = 64;
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned PA_W             = 56;
  localparam int unsigned VA_W             = 39;
  localparam int unsigned OFS_W            = 12;
  localparam int unsigned CFG_W            = 44;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MODE  = 2'd2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam int unsigned PTE_V   = 0;
  localparam int unsigned PTE_U   = 4;
  localparam int unsigned PTE_PPN = 10;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_VA_HIGH      = 3'd1,
    ST_L2_INVALID   = 3'd2,
    ST_L1_INVALID   = 3'd3,
    ST_LEAF_INVALID = 3'd4,
    ST_NOT_USER     = 3'd5,
    ST_OUTSIDE      = 3'd6
  } sptw_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LVL1,
    S_LVL0,
    S_LEAF
  } sptw_state_e;

  typedef enum logic [1:0] {
    PH_ROOT,
    PH_LVL2,
    PH_LVL1,
    PH_LEAF
  } sptw_phase_e;

  typedef struct packed {
    logic        op;
    logic [14:0] word_index;
    logic [63:0] word_data;
    logic [38:0] vaddr;
  } sptw_item_t;

  typedef struct packed {
    logic [55:0] phys_addr;
    logic [2:0]  status;
  } sptw_result_t;

  typedef struct packed {
    sptw_phase_e phase;
    logic        write;
    logic        capture;
    logic        issue;
    logic        finish;
  } sptw_cmd_t;

  typedef struct packed {
    logic stop;
  } sptw_stat_t;

endpackage

/* hdl/sptw_ctrl.sv */
// walk controller: sequences the three table reads and the result beat
// depends on sptw_pkg
module sptw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                op_i,
  input  sptw_pkg::sptw_stat_t stat_i,
  output sptw_pkg::sptw_cmd_t  cmd_o,
  output logic                busy
);

  sptw_pkg::sptw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sptw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sptw_pkg::S_IDLE: begin
        if (start && op_i == sptw_pkg::OP_TRANSLATE && !stat_i.stop) begin
          state_d = sptw_pkg::S_LVL1;
        end
      end
      sptw_pkg::S_LVL1: begin
        state_d = stat_i.stop ? sptw_pkg::S_IDLE : sptw_pkg::S_LVL0;
      end
      sptw_pkg::S_LVL0: begin
        state_d = stat_i.stop ? sptw_pkg::S_IDLE : sptw_pkg::S_LEAF;
      end
      sptw_pkg::S_LEAF: begin
        state_d = sptw_pkg::S_IDLE;
      end
      default: begin
        state_d = sptw_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '{phase: sptw_pkg::PH_ROOT, write: 1'b0, capture: 1'b0,
              issue: 1'b0, finish: 1'b0};
    busy  = 1'b1;
    case (state_q)
      sptw_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (op_i == sptw_pkg::OP_WRITE) begin
            cmd_o.write  = 1'b1;
            cmd_o.finish = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            cmd_o.issue   = !stat_i.stop;
            cmd_o.finish  = stat_i.stop;
          end
        end
      end
      sptw_pkg::S_LVL1: begin
        cmd_o.phase  = sptw_pkg::PH_LVL2;
        cmd_o.issue  = !stat_i.stop;
        cmd_o.finish = stat_i.stop;
      end
      sptw_pkg::S_LVL0: begin
        cmd_o.phase  = sptw_pkg::PH_LVL1;
        cmd_o.issue  = !stat_i.stop;
        cmd_o.finish = stat_i.stop;
      end
      sptw_pkg::S_LEAF: begin
        cmd_o.phase  = sptw_pkg::PH_LEAF;
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/sptw_dpath.sv */
// walk datapath: config registers, table store, range check, result register
// depends on sptw_pkg
module sptw_dpath #(
  parameter int unsigned STORE_PAGES = sptw_pkg::STORE_PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sptw_pkg::sptw_item_t        item_i,
  input  sptw_pkg::sptw_cmd_t         cmd_i,
  input  logic                        cfg_we_i,
  input  logic [sptw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sptw_pkg::CFG_W-1:0]  cfg_data_i,
  output sptw_pkg::sptw_stat_t        stat_o,
  output logic                        done_o,
  output sptw_pkg::sptw_result_t      result_o
);

  localparam int unsigned STORE_WORDS = STORE_PAGES * sptw_pkg::ENTRIES_PER_PAGE;
  localparam int unsigned SLOT_W      = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int unsigned ADDR_W      = SLOT_W + sptw_pkg::IDX_W;

  logic [sptw_pkg::PPN_W-1:0] root_q, base_q;
  logic                       user_q;
  logic [sptw_pkg::VA_W-1:0]  vaddr_q;
  logic [63:0]                store_q [STORE_WORDS];
  logic [63:0]                rdata_q;
  logic                       done_q;
  sptw_pkg::sptw_result_t     res_q, res_d;

  logic [sptw_pkg::PPN_W-1:0] ppn_src, slot_diff;
  logic [sptw_pkg::IDX_W-1:0] idx;
  logic                       range_bad;
  logic [ADDR_W-1:0]          raddr, waddr;
  logic                       wr_ok;
  logic                       ent_v, ent_u;
  logic                       stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      base_q <= '0;
      user_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sptw_pkg::CFG_ROOT_PAGE:  root_q <= cfg_data_i;
        sptw_pkg::CFG_STORE_BASE: base_q <= cfg_data_i;
        sptw_pkg::CFG_USER_MODE:  user_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // table page lookup
  always_comb begin
    ppn_src = (cmd_i.phase == sptw_pkg::PH_ROOT) ? root_q
                                                  : rdata_q[sptw_pkg::PTE_PPN +: sptw_pkg::PPN_W];
    case (cmd_i.phase)
      sptw_pkg::PH_ROOT: idx = item_i.vaddr[30 +: sptw_pkg::IDX_W];
      sptw_pkg::PH_LVL2: idx = vaddr_q[21 +: sptw_pkg::IDX_W];
      default:           idx = vaddr_q[12 +: sptw_pkg::IDX_W];
    endcase
    slot_diff = ppn_src - base_q;
    range_bad = (ppn_src < base_q) || (slot_diff >= sptw_pkg::PPN_W'(STORE_PAGES));
    raddr     = ADDR_W'({slot_diff[SLOT_W-1:0], idx});
    waddr     = ADDR_W'(32'(item_i.word_index));
    wr_ok     = 32'(item_i.word_index) < 32'(STORE_WORDS);
  end

  assign ent_v = rdata_q[sptw_pkg::PTE_V];
  assign ent_u = rdata_q[sptw_pkg::PTE_U];

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) begin
      store_q[waddr] <= item_i.word_data;
    end
    if (cmd_i.issue) begin
      rdata_q <= store_q[raddr];
    end
  end

  // result of the step in progress
  always_comb begin
    res_d = '{phys_addr: '0, status: sptw_pkg::ST_OK};
    stop  = 1'b0;
    case (cmd_i.phase)
      sptw_pkg::PH_ROOT: begin
        if (!cmd_i.write) begin
          if (item_i.vaddr[sptw_pkg::VA_W-1]) begin
            res_d.status = sptw_pkg::ST_VA_HIGH;
            stop         = 1'b1;
          end else if (range_bad) begin
            res_d.status = sptw_pkg::ST_OUTSIDE;
            stop         = 1'b1;
          end
        end
      end
      sptw_pkg::PH_LVL2: begin
        if (!ent_v) begin
          res_d.status = sptw_pkg::ST_L2_INVALID;
          stop         = 1'b1;
        end else if (range_bad) begin
          res_d.status = sptw_pkg::ST_OUTSIDE;
          stop         = 1'b1;
        end
      end
      sptw_pkg::PH_LVL1: begin
        if (!ent_v) begin
          res_d.status = sptw_pkg::ST_L1_INVALID;
          stop         = 1'b1;
        end else if (range_bad) begin
          res_d.status = sptw_pkg::ST_OUTSIDE;
          stop         = 1'b1;
        end
      end
      sptw_pkg::PH_LEAF: begin
        stop = 1'b1;
        if (!ent_v) begin
          res_d.status = sptw_pkg::ST_LEAF_INVALID;
        end else if (user_q && !ent_u) begin
          res_d.status = sptw_pkg::ST_NOT_USER;
        end else if (user_q) begin
          res_d.phys_addr = {ppn_src, {sptw_pkg::OFS_W{1'b0}}};
        end else begin
          res_d.phys_addr = {ppn_src, vaddr_q[sptw_pkg::OFS_W-1:0]};
        end
      end
      default: begin
        stop = 1'b1;
      end
    endcase
  end

  assign stat_o.stop = stop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vaddr_q <= item_i.vaddr;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* hdl/sv39_page_table_walker_top.sv */
// top level of the sv39 page table walker
// depends on sptw_pkg, sptw_ctrl and sptw_dpath
//
// An item is taken when start is high and busy is low. A table write is
// done in its accept cycle; a translation issues the root read in the
// accept cycle and may stop early on a failed check, and each of the two
// middle entries and the leaf is checked in the cycle after its read from
// the single-port table store, so the three dependent store reads set the
// rate. Each result beat appears on result_o for one cycle with done_o
// high, in the cycle after the walk ends; the receiver cannot stall it,
// and the next item may be accepted in that same cycle. The table store has
// no reset: every word a walk reads must be written first. Configuration
// writes take effect at once and belong to idle periods.
module sv39_page_table_walker_top #(
  parameter int unsigned STORE_PAGES = sptw_pkg::STORE_PAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  sptw_pkg::sptw_item_t           item_i,
  output logic                           done_o,
  output sptw_pkg::sptw_result_t         result_o,
  input  logic                           cfg_we_i,
  input  logic [sptw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sptw_pkg::CFG_W-1:0]     cfg_data_i
);

  sptw_pkg::sptw_cmd_t  cmd;
  sptw_pkg::sptw_stat_t stat;

  sptw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (item_i.op),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sptw_dpath #(
    .STORE_PAGES (STORE_PAGES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (stat),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result beat without a walk or accepted item");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != sptw_pkg::ST_OK) |-> result_o.phys_addr == '0)
    else $error("failed walk returned a nonzero address");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy) && $past(busy, 2)) |=> !busy)
    else $error("walk longer than three busy cycles");

  a_walk_ends_in_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without a result beat");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for sv39_page_table_walker_top: directed table walks, then random
// table builds and translations under several register settings; needs sptw_pkg and the rtl
module tb_top;
  import sptw_pkg::*;

  localparam int unsigned TBL_WORDS   = STORE_PAGES_DEF * ENTRIES_PER_PAGE;
  localparam int unsigned STALL_LIMIT = 200;

  typedef struct {
    sptw_item_t   it;
    bit           typed;
    sptw_result_t res;
  } dir_row_t;

  typedef struct {
    logic [CFG_W-1:0] root;
    logic [CFG_W-1:0] base;
    bit               user;
    int unsigned      beats;
    bit               gaps;
  } phase_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  sptw_item_t           item_i;
  logic                 done_o;
  sptw_result_t         result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  logic [63:0]      tbl_mem [0:TBL_WORDS-1];
  bit               tbl_set [0:TBL_WORDS-1];
  logic [PPN_W-1:0] root_q;
  logic [PPN_W-1:0] base_q;
  bit               user_q;

  sptw_result_t pending_results[$];
  sptw_result_t head_res;
  int unsigned  err_cnt;
  int unsigned  idle_cycles;
  bit           gaps_on;

  sv39_page_table_walker_top #(
    .STORE_PAGES(STORE_PAGES_DEF)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // walks the tables as the block should; miss names a never-written word the walk would read
  function automatic sptw_result_t predict_walk(input logic [VA_W-1:0] va, output int miss);
    sptw_result_t r;
    logic [63:0]  ppn;
    logic [63:0]  pte;
    logic [8:0]   ix;
    int unsigned  w;
    r.phys_addr = '0;
    r.status    = ST_OK;
    miss        = -1;
    pte         = '0;
    if (va[VA_W-1]) begin
      r.status = ST_VA_HIGH;
      return r;
    end
    ppn = 64'(root_q);
    for (int lvl = 2; lvl >= 0; lvl--) begin
      ix = va[OFS_W + IDX_W*lvl +: IDX_W];
      if (ppn < 64'(base_q) || ppn - 64'(base_q) >= 64'(STORE_PAGES_DEF)) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      w = int'(ppn - 64'(base_q)) * ENTRIES_PER_PAGE + int'(ix);
      if (!tbl_set[w]) begin
        miss = w;
        return r;
      end
      pte = tbl_mem[w];
      if (!pte[PTE_V]) begin
        r.status = (lvl == 2) ? ST_L2_INVALID : (lvl == 1) ? ST_L1_INVALID : ST_LEAF_INVALID;
        return r;
      end
      ppn = 64'(pte[PTE_PPN +: PPN_W]);
    end
    if (user_q && !pte[PTE_U]) begin
      r.status = ST_NOT_USER;
    end else begin
      r.phys_addr = user_q ? {ppn[PPN_W-1:0], 12'h000} : {ppn[PPN_W-1:0], va[OFS_W-1:0]};
    end
    return r;
  endfunction

  function automatic sptw_item_t wr_item(input logic [14:0] idx, input logic [63:0] data);
    sptw_item_t it;
    it.op         = OP_WRITE;
    it.word_index = idx;
    it.word_data  = data;
    it.vaddr      = VA_W'({$urandom, $urandom});
    return it;
  endfunction

  function automatic sptw_item_t tr_item(input logic [VA_W-1:0] va);
    sptw_item_t it;
    it.op         = OP_TRANSLATE;
    it.word_index = 15'($urandom);
    it.word_data  = {$urandom, $urandom};
    it.vaddr      = va;
    return it;
  endfunction

  function automatic logic [63:0] ptr_pte(input logic [PPN_W-1:0] ppn);
    logic [63:0] pte;
    pte = '0;
    pte[PTE_PPN +: PPN_W] = ppn;
    pte[PTE_V] = 1'b1;
    return pte;
  endfunction

  function automatic dir_row_t mk_row(input sptw_item_t it, input bit typed,
                                      input logic [PA_W-1:0] pa, input sptw_status_e st);
    dir_row_t row;
    row.it               = it;
    row.typed            = typed;
    row.res.phys_addr    = pa;
    row.res.status       = st;
    return row;
  endfunction

  // mostly pointers into the first store pages, some invalid, some far outside
  function automatic logic [63:0] random_pte();
    logic [63:0]      pte;
    logic [PPN_W-1:0] ppn;
    int unsigned      r;
    pte = {$urandom, $urandom};
    r   = $urandom_range(99);
    if (r < 80) begin
      ppn = base_q + PPN_W'($urandom_range(0, ($urandom_range(3) == 0) ? 63 : 7));
      pte[PTE_V] = 1'b1;
      pte[PTE_U] = ($urandom_range(9) != 0);
    end else if (r < 90) begin
      ppn = pte[PTE_PPN +: PPN_W];
      pte[PTE_V] = 1'b0;
    end else begin
      ppn = PPN_W'({$urandom, $urandom});
      pte[PTE_V] = 1'b1;
    end
    pte[PTE_PPN +: PPN_W] = ppn;
    return pte;
  endfunction

  function automatic logic [VA_W-1:0] random_va();
    logic [8:0]  ix [3];
    int unsigned r;
    for (int k = 0; k < 3; k++) begin
      r = $urandom_range(9);
      ix[k] = (r < 7) ? 9'($urandom_range(0, 3)) : (r < 8) ? 9'd511 : 9'($urandom);
    end
    ix[2][8] = ($urandom_range(19) == 0);
    return {ix[2], ix[1], ix[0], 12'($urandom)};
  endfunction

  task automatic drive_item(input sptw_item_t it, input bit typed,
                            input sptw_result_t fixed_res);
    sptw_result_t exp_res;
    int           miss;
    if (gaps_on && $urandom_range(99) < 35) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_res.phys_addr = '0;
    exp_res.status    = ST_OK;
    if (it.op == OP_WRITE) begin
      if (it.word_index < TBL_WORDS) begin
        tbl_mem[it.word_index] = it.word_data;
        tbl_set[it.word_index] = 1'b1;
      end
    end else begin
      exp_res = predict_walk(it.vaddr, miss);
    end
    if (typed) exp_res = fixed_res;
    pending_results.push_back(exp_res);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_ROOT_PAGE:  root_q = data;
      CFG_STORE_BASE: base_q = data;
      CFG_USER_MODE:  user_q = data[0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(result_o), '0);
      end else begin
        head_res = pending_results.pop_front();
        if (result_o.phys_addr !== head_res.phys_addr)
          report_mismatch("phys_addr", 64'(result_o.phys_addr), 64'(head_res.phys_addr));
        if (result_o.status !== head_res.status)
          report_mismatch("status", 64'(result_o.status), 64'(head_res.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t         dir_tbl[$];
    phase_t           plan[6];
    sptw_result_t     no_res;
    logic [VA_W-1:0]  va;
    logic [CFG_W-1:0] rbase;
    int unsigned      n;
    int               miss;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ROOT_PAGE;
    cfg_data_i  = '0;
    root_q      = '0;
    base_q      = '0;
    user_q      = 1'b1;
    err_cnt     = 0;
    idle_cycles = 0;
    gaps_on     = 1'b1;
    no_res      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: root page 0, store at page 0, user mode
    dir_tbl.push_back(mk_row(tr_item(39'h40_0000_0000), 1, '0, ST_VA_HIGH));
    dir_tbl.push_back(mk_row(tr_item('1), 1, '0, ST_VA_HIGH));
    dir_tbl.push_back(mk_row(wr_item(15'd0, '0), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item('0), 1, '0, ST_L2_INVALID));
    dir_tbl.push_back(mk_row(wr_item(15'd0, ptr_pte(44'd1)), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(wr_item(15'd512, '0), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item('0), 1, '0, ST_L1_INVALID));
    dir_tbl.push_back(mk_row(wr_item(15'd512, ptr_pte(44'd2)), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(wr_item(15'd1024, '0), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item('0), 1, '0, ST_LEAF_INVALID));
    dir_tbl.push_back(mk_row(wr_item(15'd1024, ptr_pte(44'h123)), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item(39'hABC), 1, '0, ST_NOT_USER));
    dir_tbl.push_back(mk_row(wr_item(15'd1024, ptr_pte(44'h123) | 64'hFFC0_0000_0000_0010),
                             1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item(39'hABC), 1, 56'h123000, ST_OK));
    dir_tbl.push_back(mk_row(wr_item(15'd1, ptr_pte(44'd64)), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item(39'd1 << 30), 1, '0, ST_OUTSIDE));
    dir_tbl.push_back(mk_row(wr_item(15'd32767, '1), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(wr_item(15'd2, ptr_pte(44'd63) | 64'h3FF), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item((39'd2 << 30) | (39'd511 << 21)), 1, '0, ST_OUTSIDE));
    dir_tbl.push_back(mk_row(wr_item(15'd1025, '1), 1, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item(39'h1FFF), 1, 56'hFF_FFFF_FFFF_F000, ST_OK));
    dir_tbl.push_back(mk_row(wr_item(15'd3, ptr_pte(44'd2) | 64'h10), 0, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item((39'd3 << 30) | (39'd1 << 21) | 39'h7), 0, '0, ST_OK));
    dir_tbl.push_back(mk_row(tr_item(39'h1234), 0, '0, ST_OK));
    foreach (dir_tbl[i]) drive_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].res);

    rbase   = {12'($urandom_range(0, 4094)), 32'($urandom)};
    plan[0] = '{44'd5, 44'd0, 1'b0, 200, 1'b1};
    plan[1] = '{44'd1002, 44'd1000, 1'b1, 200, 1'b1};
    plan[2] = '{44'hFFF_FFFF_FFFF, 44'hFFF_FFFF_FFC0, 1'b0, 200, 1'b0};
    plan[3] = '{44'hFFF_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 1'b1, 80, 1'b1};
    plan[4] = '{44'd0, 44'd37, 1'b0, 40, 1'b1};
    plan[5] = '{rbase + CFG_W'($urandom_range(0, 63)), rbase, 1'($urandom), 180, 1'b1};

    foreach (plan[p]) begin
      drain_results();
      write_cfg(CFG_ROOT_PAGE, plan[p].root);
      write_cfg(CFG_STORE_BASE, plan[p].base);
      write_cfg(CFG_USER_MODE, {43'($urandom), plan[p].user});
      gaps_on = plan[p].gaps;
      n = 0;
      while (n < plan[p].beats) begin
        if ($urandom_range(99) < 10) begin
          drive_item(wr_item(15'($urandom), {$urandom, $urandom}), 0, no_res);
          n++;
        end else begin
          // fill every table word the walk would reach, then translate
          va = random_va();
          for (int k = 0; k < 4; k++) begin
            void'(predict_walk(va, miss));
            if (miss < 0) break;
            drive_item(wr_item(15'(miss), random_pte()), 0, no_res);
            n++;
          end
          drive_item(tr_item(va), 0, no_res);
          n++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
